// ===== rtl/utc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// utc_pkg: shared types and constants of the UTF-8 to CP1251 transcoder
// Result and input item layouts, decoder constants and the code point
// mapping function used by the decoder.
// ---------------------------------------------------------------------------
package utc_pkg;

  localparam logic [7:0] QMARK      = 8'h3F;
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;

  localparam logic [15:0] CYR_FIRST  = 16'h0410;
  localparam logic [15:0] CYR_LAST   = 16'h044F;
  localparam logic [15:0] CP_IO_UP   = 16'h0401;
  localparam logic [15:0] CP_IO_LOW  = 16'h0451;
  localparam logic [15:0] CP_ASCII   = 16'h0080;
  localparam logic [7:0]  CYR_BASE   = 8'hC0;
  localparam logic [7:0]  CH_IO_UP   = 8'hA8;
  localparam logic [7:0]  CH_IO_LOW  = 8'hB8;

  localparam logic [15:0] MAX_OUTPUT_RESET = 16'd4095;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       replaced;
    logic       end_of_string;
  } result_t;

  // Up to two results per request, already filtered by the output limit;
  // the kept results always form a prefix (r0 first).
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } dec_out_t;

  typedef struct packed {
    logic       rep;
    logic [7:0] ch;
  } mapped_t;

  function automatic mapped_t map_code(input logic [15:0] code);
    mapped_t    m;
    logic [15:0] off;
    off   = code - CYR_FIRST;
    m.rep = 1'b0;
    m.ch  = QMARK;
    if (code < CP_ASCII) begin
      m.ch = code[7:0];
    end else if (code >= CYR_FIRST && code <= CYR_LAST) begin
      m.ch = CYR_BASE + off[7:0];
    end else if (code == CP_IO_UP) begin
      m.ch = CH_IO_UP;
    end else if (code == CP_IO_LOW) begin
      m.ch = CH_IO_LOW;
    end else begin
      m.rep = 1'b1;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/utc_in_reg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// utc_in_reg: input register stage
// Captures one input request per cycle while the decoder keeps taking them,
// and holds each until the decoder takes it.
// ---------------------------------------------------------------------------
module utc_in_reg
  import utc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] byte_in
  input  wire logic       s_axis_tlast,   // last_in
  input  wire logic       take,
  output logic            item_valid,
  output in_item_t        item
);

  logic     valid;
  in_item_t data;

  assign s_axis_tready = !valid || take;
  assign item_valid    = valid;
  assign item          = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_axis_tready) begin
      valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      data.byte_in <= s_axis_tdata;
      data.last_in <= s_axis_tlast;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/utc_decoder.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// utc_decoder: UTF-8 sequence decoder and output limiter
// Holds partial sequences, maps code points to CP1251 and applies the
// per-string result limit.
// ---------------------------------------------------------------------------
module utc_decoder
  import utc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire in_item_t    item,
  input  wire logic [15:0] max_output,
  output dec_out_t         dec_out
);

  typedef enum logic [2:0] {
    HOLD_NONE   = 3'b001,
    HOLD_LEAD   = 3'b010,
    HOLD_FOLLOW = 3'b100
  } hold_state_t;

  hold_state_t state, state_next;
  logic [7:0]  held_lead, held_lead_next;
  logic [7:0]  held_follower, held_follower_next;
  logic [15:0] emitted_count, emitted_count_next;

  logic [1:0]  n_raw;
  logic [7:0]  ch0, ch1;
  logic        rp0, rp1;
  logic [15:0] code2, code3;
  mapped_t     m2, m3;
  logic        b_ascii, b_lead, h_lead2;
  logic        keep0, keep1;
  logic [16:0] ec_plus1;
  logic [1:0]  n_kept;

  assign code2   = {5'd0, held_lead[4:0], item.byte_in[5:0]};
  assign code3   = {held_lead[3:0], held_follower[5:0], item.byte_in[5:0]};
  assign m2      = map_code(code2);
  assign m3      = map_code(code3);
  assign b_ascii = (item.byte_in & ASCII_MASK) == 8'd0;
  assign b_lead  = ((item.byte_in & LEAD2_MASK) == LEAD2_CODE) ||
                   ((item.byte_in & LEAD3_MASK) == LEAD3_CODE);
  assign h_lead2 = (held_lead & LEAD2_MASK) == LEAD2_CODE;

  always_comb begin
    n_raw              = 2'd0;
    ch0                = QMARK;
    rp0                = 1'b1;
    ch1                = QMARK;
    rp1                = 1'b1;
    state_next         = HOLD_NONE;
    held_lead_next     = held_lead;
    held_follower_next = held_follower;
    unique case (state)
      HOLD_LEAD: begin
        if (h_lead2) begin
          n_raw = 2'd1;
          ch0   = m2.ch;
          rp0   = m2.rep;
        end else if (item.last_in) begin
          // Truncated three-byte sequence: the lead gives a replacement and
          // the follower is decoded again on its own.
          n_raw = 2'd2;
          if (b_ascii) begin
            ch1 = item.byte_in;
            rp1 = 1'b0;
          end
        end else begin
          held_follower_next = item.byte_in;
          state_next         = HOLD_FOLLOW;
        end
      end
      HOLD_FOLLOW: begin
        n_raw = 2'd1;
        ch0   = m3.ch;
        rp0   = m3.rep;
      end
      default: begin
        if (b_ascii) begin
          n_raw = 2'd1;
          ch0   = item.byte_in;
          rp0   = 1'b0;
        end else if (b_lead && !item.last_in) begin
          held_lead_next = item.byte_in;
          state_next     = HOLD_LEAD;
        end else begin
          n_raw = 2'd1;
        end
      end
    endcase
  end

  // Results are kept while the string stays below its limit.
  assign ec_plus1 = {1'b0, emitted_count} + 17'd1;
  assign keep0    = emitted_count < max_output;
  assign keep1    = keep0 && (ec_plus1 < {1'b0, max_output});

  always_comb begin
    case (n_raw)
      2'd1:    n_kept = {1'b0, keep0};
      2'd2:    n_kept = {1'b0, keep0} + {1'b0, keep1};
      default: n_kept = 2'd0;
    endcase
  end

  always_comb begin
    dec_out.n                = n_kept;
    dec_out.r0.char_out      = ch0;
    dec_out.r0.replaced      = rp0;
    dec_out.r0.end_of_string = item.last_in && (n_kept == 2'd1);
    dec_out.r1.char_out      = ch1;
    dec_out.r1.replaced      = rp1;
    dec_out.r1.end_of_string = item.last_in && (n_kept == 2'd2);
  end

  assign emitted_count_next = item.last_in ? 16'd0 : emitted_count + {14'd0, n_kept};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= HOLD_NONE;
      emitted_count <= 16'd0;
    end else if (fire) begin
      state         <= item.last_in ? HOLD_NONE : state_next;
      emitted_count <= emitted_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_lead     <= held_lead_next;
      held_follower <= held_follower_next;
    end
  end

`ifndef ASSERT_OFF
  a_two_only_truncated: assert property (@(posedge clk) disable iff (rst)
    (dec_out.n == 2'd2) |-> (state == HOLD_LEAD && item.last_in && !h_lead2))
    else $error("two results outside a truncated three-byte sequence");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && item.last_in) |=> (state == HOLD_NONE && emitted_count == 16'd0))
    else $error("string end did not clear the held state");
  a_kept_prefix: assert property (@(posedge clk) disable iff (rst)
    (dec_out.n != 2'd0) |-> keep0)
    else $error("result kept beyond the output limit");
`endif

endmodule
`default_nettype wire

// ===== rtl/utc_out_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// utc_out_fifo: result queue
// Takes up to two results per cycle from the decoder while it has room for
// two, and hands them out one per cycle while the receiver is ready.
// ---------------------------------------------------------------------------
module utc_out_fifo
  import utc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire dec_out_t push_data,
  output logic          room,
  output logic          head_valid,
  output result_t       head,
  input  wire logic     pop_ready
);

  result_t                 entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_CNT_W-1:0]   cnt, cnt_next;
  logic [1:0]              push_n;
  logic                    pop;

  assign push_n      = push ? push_data.n : 2'd0;
  assign pop         = head_valid && pop_ready;
  assign room        = cnt <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign head_valid  = cnt != '0;
  assign head        = entries[rd_ptr];
  assign wr_ptr_next = wr_ptr + FIFO_PTR_W'(push_n);
  assign cnt_next    = cnt + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      cnt    <= cnt_next;
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= push_data.r0;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr + FIFO_PTR_W'(1)] <= push_data.r1;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> room)
    else $error("results pushed without room");
`endif

endmodule
`default_nettype wire

// ===== rtl/utf8_to_cp1251_transcoder_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// utf8_to_cp1251_transcoder_unit: UTF-8 to CP1251 byte-stream transcoder
// Decodes a UTF-8 byte stream and gives one CP1251 byte per code point.
// ---------------------------------------------------------------------------
// The block takes one UTF-8 byte per cycle on the input stream while the
// result queue has room, and emits one CP1251 byte for each decoded code
// point on the output stream. Each input request is decoded while it sits
// in the input register, and its results enter the four-entry result queue,
// from which they are offered, once it has room for both. The sustained rate
// is one input byte per cycle while the output side takes results. Lead
// bytes of two- and three-byte sequences produce nothing until their
// followers arrive; the only byte that yields two results is the one that
// ends a string as the first follower of a three-byte sequence. Input is
// taken while the queue has room for two results, so a stalled output side
// holds back the input after a few requests. Continuation bits of followers
// are not checked, and stray, four-byte or unmappable input gives '?' with
// the replaced flag set. The configuration register max_output caps the
// results of one string; results past it are dropped and a string whose
// final byte keeps no result carries no end marker. Write max_output only
// while the block is idle.
// ---------------------------------------------------------------------------
module utf8_to_cp1251_transcoder_unit
  import utc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  wire logic        s_axis_tlast,   // last_in
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] char_out
  output logic [0:0]       m_axis_tuser,   // [0] replaced
  output logic             m_axis_tlast,   // end_of_string
  // Configuration write channel (max_output)
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic        item_valid;
  in_item_t    item;
  logic        take;
  logic        room;
  dec_out_t    dec_out;
  result_t     head;
  logic [15:0] max_output;

  // A held request is decoded once the queue can take both of its results.
  assign take = item_valid && room;

  // The register is always writable; the user must write it only while idle, and the block does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_output <= MAX_OUTPUT_RESET;
    end else if (cfg_valid) begin
      max_output <= cfg_data;
    end
  end

  utc_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .take          (take),
    .item_valid    (item_valid),
    .item          (item)
  );

  utc_decoder u_decoder (
    .clk        (clk),
    .rst        (rst),
    .fire       (take),
    .item       (item),
    .max_output (max_output),
    .dec_out    (dec_out)
  );

  utc_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_data  (dec_out),
    .room       (room),
    .head_valid (m_axis_tvalid),
    .head       (head),
    .pop_ready  (m_axis_tready)
  );

  assign m_axis_tdata    = head.char_out;
  assign m_axis_tuser[0] = head.replaced;
  assign m_axis_tlast    = head.end_of_string;

`ifndef ASSERT_OFF
  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    take |-> item_valid)
    else $error("decoder fired without a held request");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/cp1251_stream_checker.sv =====
// ---------------------------------------------------------------------------
// cp1251_stream_checker: result prediction and comparison for the transcoder
// Watches the input, output and configuration channels, decodes every
// accepted UTF-8 byte into the CP1251 results it must cause and compares
// each accepted result with the oldest one still awaited.
// ---------------------------------------------------------------------------
module cp1251_stream_checker
  import utc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  wire logic        s_axis_tlast,   // last_in
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [7:0]  m_axis_tdata,   // [7:0] char_out
  input  wire logic [0:0]  m_axis_tuser,   // [0] replaced
  input  wire logic        m_axis_tlast,   // end_of_string
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [15:0] cfg_data,
  output int               pending_results,
  output int               mismatch_count
);

  localparam logic [1:0] HOLD_NONE          = 2'd0;
  localparam logic [1:0] HOLD_LEAD          = 2'd1;
  localparam logic [1:0] HOLD_LEAD_FOLLOWER = 2'd2;

  logic [15:0] max_output;
  logic [7:0]  lead_byte;
  logic [7:0]  follower_byte;
  logic [1:0]  held_state;
  logic [15:0] chars_emitted;
  result_t     expected_chars[$];

  // Returns {replaced, char} for one code point.
  function automatic logic [8:0] cp1251_of(input logic [15:0] cp);
    logic [15:0] offset;
    offset = cp - CYR_FIRST;
    if (cp < CP_ASCII) return {1'b0, cp[7:0]};
    if (cp >= CYR_FIRST && cp <= CYR_LAST) return {1'b0, CYR_BASE + offset[7:0]};
    if (cp == CP_IO_UP) return {1'b0, CH_IO_UP};
    if (cp == CP_IO_LOW) return {1'b0, CH_IO_LOW};
    return {1'b1, QMARK};
  endfunction

  task automatic decode_utf8_byte(input logic [7:0] b, input logic last);
    logic [8:0]  found [2];
    result_t     kept [2];
    int          n_found;
    int          n_kept;
    logic [15:0] cp;
    n_found = 0;
    n_kept  = 0;
    case (held_state)
      HOLD_LEAD: begin
        if ((lead_byte & LEAD2_MASK) == LEAD2_CODE) begin
          cp = {5'd0, lead_byte[4:0], b[5:0]};
          found[0]   = cp1251_of(cp);
          n_found    = 1;
          held_state = HOLD_NONE;
        end else if (last) begin
          // The held lead is given up and the follower is taken as a lone byte.
          found[0]   = {1'b1, QMARK};
          found[1]   = ((b & ASCII_MASK) == 8'h00) ? {1'b0, b} : {1'b1, QMARK};
          n_found    = 2;
          held_state = HOLD_NONE;
        end else begin
          follower_byte = b;
          held_state    = HOLD_LEAD_FOLLOWER;
        end
      end
      HOLD_LEAD_FOLLOWER: begin
        cp = {lead_byte[3:0], follower_byte[5:0], b[5:0]};
        found[0]   = cp1251_of(cp);
        n_found    = 1;
        held_state = HOLD_NONE;
      end
      default: begin
        if ((b & ASCII_MASK) == 8'h00) begin
          found[0] = {1'b0, b};
          n_found  = 1;
        end else if ((b & LEAD2_MASK) == LEAD2_CODE || (b & LEAD3_MASK) == LEAD3_CODE) begin
          if (last) begin
            found[0] = {1'b1, QMARK};
            n_found  = 1;
          end else begin
            lead_byte  = b;
            held_state = HOLD_LEAD;
          end
        end else begin
          found[0] = {1'b1, QMARK};
          n_found  = 1;
        end
      end
    endcase
    for (int k = 0; k < n_found; k++) begin
      if (chars_emitted < max_output) begin
        kept[n_kept].char_out      = found[k][7:0];
        kept[n_kept].replaced      = found[k][8];
        kept[n_kept].end_of_string = 1'b0;
        n_kept++;
        chars_emitted++;
      end
    end
    if (last) begin
      if (n_kept > 0) kept[n_kept-1].end_of_string = 1'b1;
      held_state    = HOLD_NONE;
      chars_emitted = '0;
    end
    for (int k = 0; k < n_kept; k++) expected_chars.push_back(kept[k]);
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      max_output     = MAX_OUTPUT_RESET;
      lead_byte      = '0;
      follower_byte  = '0;
      held_state     = HOLD_NONE;
      chars_emitted  = '0;
      mismatch_count = 0;
      expected_chars.delete();
    end else begin
      if (cfg_valid && cfg_ready) max_output = cfg_data;
      if (s_axis_tvalid && s_axis_tready) decode_utf8_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected result: expected none, got char_out=%02h replaced=%0b end_of_string=%0b",
                   $time, m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
          mismatch_count++;
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata !== want.char_out) begin
            $display("%0t: char_out mismatch: expected %02h, got %02h",
                     $time, want.char_out, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tuser[0] !== want.replaced) begin
            $display("%0t: replaced mismatch: expected %0b, got %0b",
                     $time, want.replaced, m_axis_tuser[0]);
            mismatch_count++;
          end
          if (m_axis_tlast !== want.end_of_string) begin
            $display("%0t: end_of_string mismatch: expected %0b, got %0b",
                     $time, want.end_of_string, m_axis_tlast);
            mismatch_count++;
          end
        end
      end
    end
    pending_results = expected_chars.size();
  end

endmodule

// ===== tb/sv/utf8_to_cp1251_transcoder_unit_tb.sv =====
// ---------------------------------------------------------------------------
// utf8_to_cp1251_transcoder_unit_tb: stimulus and verdict for the transcoder
// Drives hand-picked byte sequences and then random strings built mostly from
// well-formed UTF-8, under several output limits and idling patterns, while a
// checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module utf8_to_cp1251_transcoder_unit_tb;
  import utc_pkg::*;

  // The limit lies well above the slowest legal run; this leaves a wide margin
  // for the random idling.
  localparam int CYCLE_LIMIT  = 400000;
  // Cycles allowed after the last awaited result, so that a byte still in
  // the input register (a lead byte causes no result) has left the block.
  localparam int SETTLE       = 8;
  // Length of the long receiver hold-off used to fill the result queue.
  localparam int LONG_HOLD    = 120;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] byte_in
  logic        s_axis_tlast  = 1'b0;    // last_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;            // [7:0] char_out
  logic [0:0]  m_axis_tuser;            // [0] replaced
  logic        m_axis_tlast;            // end_of_string
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data      = 16'h0000;

  int pending_results;
  int mismatch_count;

  // Idling percentages of the current phase, and the bookkeeping of long
  // hold-offs: the stimulus asks, the receiver process serves and counts.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;
  int bytes_sent   = 0;
  int cycles;

  utf8_to_cp1251_transcoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  cp1251_stream_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  always #1 clk = ~clk;

  // Receiver: drives tready at each falling edge. A long hold-off, once asked
  // for, is counted down here; otherwise the stall rate of the phase applies.
  always @(negedge clk) begin
    if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: a run that has not finished by the limit has hung.
  initial begin
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("FAIL utf8_to_cp1251_transcoder_unit");
    $finish;
  end

  // Offers one byte, starting and returning at a falling edge. The valid is
  // left high on return so that back-to-back requests keep it high; a random
  // idle gap lowers it first.
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic write_max_output(input logic [15:0] value);
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stops offering, waits for every awaited result and for the pipeline to
  // empty, then sets the output limit and the idling of the next phase. The
  // idling figures change just after a rising edge so that the receiver
  // process never reads them in the same step.
  task automatic enter_phase(input int tx_pct, input int rx_pct, input logic [15:0] limit);
    s_axis_tvalid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    write_max_output(limit);
    @(posedge clk);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    @(negedge clk);
  endtask

  // A follower byte: usually a proper continuation byte, sometimes any
  // non-zero value, since continuation bits are not checked.
  function automatic logic [7:0] pick_follower();
    if ($urandom_range(3) != 0) return 8'($urandom_range(8'hBF, 8'h80));
    return 8'($urandom_range(255, 1));
  endfunction

  // Builds one string out of random units and sends it, with last on the
  // final byte. Most units are well-formed characters; the rest are stray
  // bytes, lone leads and three-byte sequences cut after one follower.
  task automatic send_random_string(input int max_units);
    logic [7:0]  seq[$];
    int          units;
    int          kind;
    logic [15:0] cp;
    units = $urandom_range(max_units, 1);
    repeat (units) begin
      kind = $urandom_range(99);
      if (kind < 28) begin
        seq.push_back(8'($urandom_range(127, 1)));
      end else if (kind < 55) begin
        // Cyrillic letters including both forms of IO, plus the code points
        // just outside the letter block.
        case ($urandom_range(11))
          0:       cp = CP_IO_UP;
          1:       cp = CP_IO_LOW;
          2:       cp = CYR_FIRST - 16'd1;
          3:       cp = CYR_LAST + 16'd1;
          4:       cp = CYR_FIRST;
          5:       cp = CYR_LAST;
          default: cp = CYR_FIRST + 16'($urandom_range(63));
        endcase
        seq.push_back({3'b110, cp[10:6]});
        seq.push_back({2'b10, cp[5:0]});
      end else if (kind < 67) begin
        seq.push_back({3'b110, 5'($urandom_range(31))});
        seq.push_back(pick_follower());
      end else if (kind < 80) begin
        // Three-byte forms, now and then an overlong Cyrillic letter.
        if ($urandom_range(3) == 0) cp = CYR_FIRST + 16'($urandom_range(65));
        else cp = 16'($urandom_range(16'hFFFF));
        seq.push_back({4'b1110, cp[15:12]});
        if ($urandom_range(4) == 0) begin
          seq.push_back(pick_follower());
          seq.push_back(pick_follower());
        end else begin
          seq.push_back({2'b10, cp[11:6]});
          seq.push_back({2'b10, cp[5:0]});
        end
      end else if (kind < 88) begin
        if ($urandom_range(1) == 0) seq.push_back(8'($urandom_range(8'hBF, 8'h80)));
        else seq.push_back(8'($urandom_range(8'hFF, 8'hF0)));
      end else if (kind < 94) begin
        // A lone lead swallows whatever byte follows it.
        if ($urandom_range(1) == 0) seq.push_back({3'b110, 5'($urandom_range(31))});
        else seq.push_back({4'b1110, 4'($urandom_range(15))});
      end else begin
        seq.push_back({4'b1110, 4'($urandom_range(15))});
        seq.push_back(8'($urandom_range(255, 1)));
      end
    end
    foreach (seq[i]) push_byte(seq[i], i == seq.size() - 1);
  endtask

  task automatic run_strings(input int count, input int max_units);
    int target;
    target = bytes_sent + count;
    while (bytes_sent < target) send_random_string(max_units);
  endtask

  initial begin
    logic [8:0] directed_q[$];

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Hand-picked sequences under the reset limit, each entry {last, byte}:
    // ASCII extremes, the overlong zero, the Cyrillic block edges and both
    // IO letters, a code point just below the block, an overlong three-byte
    // letter, an unmappable three-byte code, stray continuation and
    // four-byte leads, a lead at the end of a string, and strings ending
    // after one follower of a three-byte sequence.
    directed_q = {9'h141, 9'h101,
                  9'h07F, 9'h0C0, 9'h180,
                  9'h0D0, 9'h090, 9'h0D1, 9'h08F, 9'h0D0, 9'h081, 9'h0D1, 9'h191,
                  9'h0D0, 9'h08F, 9'h0E0, 9'h090, 9'h090, 9'h0EF, 9'h0BF, 9'h1BF,
                  9'h080, 9'h0BF, 9'h0F0, 9'h1FF,
                  9'h1C2,
                  9'h0E2, 9'h182,
                  9'h0E2, 9'h141};
    foreach (directed_q[i]) push_byte(directed_q[i][7:0], directed_q[i][8]);

    // Random phases over the range of output limits, the extremes included.
    enter_phase(0, 0, 16'hFFFF);
    run_strings(300, 6);
    enter_phase(81, 0, 16'hFFFF);
    run_strings(250, 6);
    enter_phase(0, 81, 16'd1);
    run_strings(250, 3);
    enter_phase(18, 18, 16'd0);
    run_strings(40, 4);
    enter_phase(18, 18, 16'd2);
    run_strings(250, 4);
    enter_phase(0, 0, 16'd3);
    run_strings(200, 5);

    // Back pressure: the receiver holds off for a long stretch while the
    // sender keeps offering, so the result queue fills and input stalls.
    enter_phase(0, 0, 16'($urandom_range(12, 4)));
    @(posedge clk);
    holds_asked++;
    @(negedge clk);
    run_strings(60, 6);

    enter_phase(18, 18, MAX_OUTPUT_RESET);
    run_strings(300, 8);
    enter_phase(0, 81, 16'($urandom_range(16'hFFFF)));
    run_strings(200, 6);

    // Wind down: wait for every awaited result, then wait out SETTLE to catch
    // anything stray.
    s_axis_tvalid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("PASS utf8_to_cp1251_transcoder_unit");
    end else begin
      $display("FAIL utf8_to_cp1251_transcoder_unit");
    end
    $finish;
  end

endmodule
